// ----- rtl/pns_pkg.sv -----
// ---------------------------------------------------------------------------
// pns_pkg
// Shared constants for the non-preemptive priority scheduler.
// ---------------------------------------------------------------------------
package pns_pkg;

    localparam int Q_DEPTH = 16;
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int IDX_W   = $clog2(Q_DEPTH);

    localparam int ID_W    = 8;
    localparam int PRIO_W  = 8;
    localparam int RCNT_W  = 5;
    localparam int SWC_W   = 32;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef logic [ID_W-1:0]   t_id;
    typedef logic [PRIO_W-1:0] t_prio;
    typedef logic [CNT_W-1:0]  t_cnt;

endpackage

// ----- rtl/priority_nonpreemptive_scheduler.sv -----
// A command is captured into the input registers and acted on from there;
// its result is strobed out on o_valid by r_out_valid, with the new state.
// Throughput: one command per cycle while busy is low; the ready queue is
// a row of registers, a sorted insert compares all entries in parallel and a head pop shifts them all.
// busy is high only while reset is applied and in the cycle after it.
// Reset (synchronous, active low) empties the queue, goes idle and
// clears the switch counter.
// ---------------------------------------------------------------------------
// priority_nonpreemptive_scheduler
// Non-preemptive priority scheduler with a sorted ready queue.
// ---------------------------------------------------------------------------
module priority_nonpreemptive_scheduler
    import pns_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_command,
    input  logic [ID_W-1:0]   i_task_id,
    input  logic [PRIO_W-1:0] i_task_priority,
    output logic              o_valid,
    output logic              o_running_valid,
    output logic [ID_W-1:0]   o_running_id,
    output logic [PRIO_W-1:0] o_running_priority,
    output logic [RCNT_W-1:0] o_ready_count,
    output logic [SWC_W-1:0]  o_switch_count,
    output logic              o_dropped
);

    logic              r_ready;
    logic              r_in_valid;
    logic              r_cmd;
    t_id               r_id;
    t_prio             r_prio;

    t_id               r_q_id   [Q_DEPTH];
    t_prio             r_q_prio [Q_DEPTH];
    t_cnt              r_count;
    logic              r_cur_valid;
    t_id               r_cur_id;
    t_prio             r_cur_prio;
    logic [SWC_W-1:0]  r_switch;
    logic              r_drop;
    logic              r_out_valid;

    logic [Q_DEPTH-1:0] ge;
    logic               q_full;
    logic               q_empty;
    logic               do_start;
    logic               do_insert;
    logic               do_drop;
    logic               do_pop;
    logic               do_idle;

    assign busy    = ~r_ready;
    assign q_full  = (r_count == t_cnt'(Q_DEPTH));
    assign q_empty = (r_count == '0);

    always_comb begin
        for (int k = 0; k < Q_DEPTH; k++) begin
            ge[k] = (t_cnt'(k) < r_count) && (r_q_prio[k] >= r_prio);
        end
    end

    always_comb begin
        do_start  = 1'b0;
        do_insert = 1'b0;
        do_drop   = 1'b0;
        do_pop    = 1'b0;
        do_idle   = 1'b0;
        if (r_in_valid) begin
            case (r_cmd)
                CMD_ADD: begin
                    do_start  = ~r_cur_valid;
                    do_insert = r_cur_valid & ~q_full;
                    do_drop   = r_cur_valid & q_full;
                end
                CMD_FINISH: begin
                    do_pop  = r_cur_valid & ~q_empty;
                    do_idle = r_cur_valid & q_empty;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready    <= 1'b0;
            r_in_valid <= 1'b0;
        end else begin
            r_ready    <= 1'b1;
            r_in_valid <= start & r_ready;
        end
        if (start && r_ready) begin
            r_cmd  <= i_command;
            r_id   <= i_task_id;
            r_prio <= i_task_priority;
        end
    end

    // queue storage: shifted in place on insert and pop
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < Q_DEPTH; k++) begin
            if (do_insert && !ge[k]) begin
                if (k == 0 || ge[(k == 0) ? 0 : k - 1]) begin
                    r_q_id[k]   <= r_id;
                    r_q_prio[k] <= r_prio;
                end else begin
                    r_q_id[k]   <= r_q_id[(k == 0) ? 0 : k - 1];
                    r_q_prio[k] <= r_q_prio[(k == 0) ? 0 : k - 1];
                end
            end else if (do_pop && k < Q_DEPTH - 1) begin
                r_q_id[k]   <= r_q_id[(k < Q_DEPTH - 1) ? k + 1 : k];
                r_q_prio[k] <= r_q_prio[(k < Q_DEPTH - 1) ? k + 1 : k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cur_valid <= 1'b0;
            r_cur_id    <= '0;
            r_cur_prio  <= '0;
            r_switch    <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
            r_drop      <= do_drop;
            if (do_start) begin
                r_cur_valid <= 1'b1;
                r_cur_id    <= r_id;
                r_cur_prio  <= r_prio;
                r_switch    <= r_switch + 1'b1;
            end else if (do_insert) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop) begin
                r_cur_id   <= r_q_id[0];
                r_cur_prio <= r_q_prio[0];
                r_count    <= r_count - 1'b1;
                r_switch   <= r_switch + 1'b1;
            end else if (do_idle) begin
                r_cur_valid <= 1'b0;
                r_cur_id    <= '0;
                r_cur_prio  <= '0;
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_running_valid    = r_cur_valid;
    assign o_running_id       = r_cur_id;
    assign o_running_priority = r_cur_prio;
    assign o_ready_count      = RCNT_W'(r_count);
    assign o_switch_count     = r_switch;
    assign o_dropped          = r_drop;

endmodule

// ----- rtl/pns_checker.sv -----
// ---------------------------------------------------------------------------
// pns_checker
// Port-level checks for the priority scheduler, bound to the top level.
// ---------------------------------------------------------------------------
module pns_checker
    import pns_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic              o_running_valid,
    input logic [ID_W-1:0]   o_running_id,
    input logic [PRIO_W-1:0] o_running_priority,
    input logic [RCNT_W-1:0] o_ready_count,
    input logic [SWC_W-1:0]  o_switch_count,
    input logic              o_dropped
);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##2 o_valid)
        else $error("transfer without result two cycles later");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_running_valid |-> (o_running_id == '0) && (o_running_priority == '0)
            && (o_ready_count == '0))
        else $error("idle scheduler shows a task or a queue");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dropped |-> o_ready_count == RCNT_W'(Q_DEPTH))
        else $error("drop flagged with room in the queue");

    a_switch_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 ((o_switch_count == $past(o_switch_count))
            || (o_switch_count == $past(o_switch_count) + 1'b1)))
        else $error("switch count jumped");

    a_no_switch_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dropped |-> $stable(o_switch_count))
        else $error("dropped add changed the switch count");

endmodule

bind priority_nonpreemptive_scheduler pns_checker u_pns_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_valid            (o_valid),
    .o_running_valid    (o_running_valid),
    .o_running_id       (o_running_id),
    .o_running_priority (o_running_priority),
    .o_ready_count      (o_ready_count),
    .o_switch_count     (o_switch_count),
    .o_dropped          (o_dropped)
);
